// File: rtl/msht_pkg.sv
package msht_pkg;

    localparam int ADDR_W     = 48;
    localparam int ID_W       = 8;
    localparam int STATUS_W   = 3;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REQUEST  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RESPOND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ENTRY = 3'd4;

    // input actions
    localparam logic ACT_MISS = 1'b0;
    localparam logic ACT_FILL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEVEL = 2'd2;

    localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST = 4'd6;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] byte_addr;
        logic [ID_W-1:0]   txn_id;
        logic              is_prefetch;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   line_addr;
        logic [ID_W-1:0]     resp_id;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] line_shift;
        logic               use_table;
        logic               first_level;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic drain;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_drain;
        logic drain_last;
    } sts_t;

endpackage

// File: rtl/miss_status_holding_table.sv
// channel  | signals                        | handshake
// ---------+--------------------------------+----------------------------------
// request  | start, busy, req               | taken when start && !busy
// result   | result_valid, result           | each word shown for one cycle, no stall
// config   | cfg_we, cfg_idx, cfg_data      | written when cfg_we, no wait
//
// a miss, a bypassed word or a fill without a tracked line goes through capture,
// then a lookup step with a parallel compare over all entries.
// a fill that hits then drains its n waiting tags, one tag per cycle
// through the single read port of the target ram.
// each result is registered and appears in the cycle after the one that produced it.
// reset clears the valid bits, not the entry lines or the target ram; no clearing pass is needed.
module miss_status_holding_table #(
    parameter int ENTRIES     = 16,
    parameter int MAX_TARGETS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  msht_pkg::req_t                      req,
    output logic                                result_valid,
    output msht_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [msht_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [msht_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import msht_pkg::*;

    logic [SHIFT_W-1:0] line_shift_reg;
    logic               use_table_reg;
    logic               first_level_reg;
    cfg_t               cfg;
    cmd_t               cmd;
    sts_t               sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_shift_reg  <= LINE_SHIFT_RST;
            use_table_reg   <= 1'b1;
            first_level_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_LINE_SHIFT:  line_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_USE_TABLE:   use_table_reg   <= cfg_data[0];
                CFG_FIRST_LEVEL: first_level_reg <= cfg_data[0];
                default:         line_shift_reg  <= line_shift_reg;
            endcase
        end
    end

    assign cfg = {line_shift_reg, use_table_reg, first_level_reg};

    msht_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .cmd  (cmd),
        .sts  (sts)
    );

    msht_dp #(
        .ENTRIES    (ENTRIES),
        .MAX_TARGETS(MAX_TARGETS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .cmd         (cmd),
        .sts         (sts),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

// File: rtl/msht_ram.sv
module msht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/msht_ctrl.sv
module msht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output msht_pkg::cmd_t cmd,
    input  msht_pkg::sts_t sts
);
    import msht_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.lookup  = 1'b0;
        cmd.drain   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.go_drain ? S_DRAIN : S_IDLE;
            end
            S_DRAIN:
            begin
                cmd.drain = 1'b1;
                if (sts.drain_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTH
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_LOOKUP))
        else $error("accepted word did not enter lookup");
    a_drain_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |->
            ($past(state_reg) == S_LOOKUP || $past(state_reg) == S_DRAIN))
        else $error("drain entered without lookup");
    a_drain_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && sts.drain_last) |=> (state_reg == S_IDLE))
        else $error("drain did not end on last target");
`endif

endmodule

// File: rtl/msht_dp.sv
module msht_dp #(
    parameter int ENTRIES     = 16,
    parameter int MAX_TARGETS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msht_pkg::cfg_t    cfg,
    input  msht_pkg::req_t    req,
    input  msht_pkg::cmd_t    cmd,
    output msht_pkg::sts_t    sts,
    output logic              result_valid,
    output msht_pkg::result_t result
);
    import msht_pkg::*;

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CW = $clog2(MAX_TARGETS + 1);
    localparam int RAM_DEPTH = 1 << (EW + SW);

    req_t              in_reg;
    logic [ADDR_W-1:0] line_reg;

    logic              entry_valid_reg [ENTRIES];
    logic [ADDR_W-1:0] entry_line_reg  [ENTRIES];
    logic [CW-1:0]     target_count_reg [ENTRIES];

    logic [EW-1:0] ent_reg, ent_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] k_plus;

    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic [ENTRIES-1:0] match_vec;
    logic               hit, has_free;
    logic [EW-1:0]      hit_idx, free_idx;
    logic [CW-1:0]      cnt_hit;

    logic               alloc, merge, release_ent;
    logic               ram_we;
    logic [EW+SW-1:0]   ram_waddr, ram_raddr;
    logic [ID_W-1:0]    ram_rdata;
    logic               bypass_miss;
    logic               go_drain;
    logic               drain_last;

    // parallel tag compare and lowest free entry
    always_comb
    begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = entry_valid_reg[i] && (entry_line_reg[i] == line_reg);
            if (match_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = EW'(i);
            end
            if (!entry_valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = EW'(i);
            end
        end
    end

    assign cnt_hit     = target_count_reg[hit_idx];
    assign k_plus      = k_reg + CW'(1);
    assign drain_last  = (k_plus == target_count_reg[ent_reg]);
    assign bypass_miss = !cfg.use_table || (cfg.first_level && in_reg.is_prefetch);
    assign sts         = {go_drain, drain_last};

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ent_next          = ent_reg;
        k_next            = k_reg;
        alloc             = 1'b0;
        merge             = 1'b0;
        release_ent       = 1'b0;
        go_drain          = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = {free_idx, SW'(0)};
        ram_raddr         = {ent_reg, k_plus[SW-1:0]};
        if (cmd.lookup)
        begin
            result_next.line_addr = line_reg;
            result_next.resp_id   = in_reg.txn_id;
            result_next.last      = 1'b1;
            if (in_reg.action == ACT_MISS)
            begin
                result_valid_next = 1'b1;
                if (bypass_miss)
                begin
                    result_next.status = ST_REQUEST;
                end
                else if (hit)
                begin
                    if (cnt_hit >= CW'(MAX_TARGETS))
                    begin
                        result_next.status = ST_STALL;
                    end
                    else
                    begin
                        merge              = 1'b1;
                        ram_we             = 1'b1;
                        ram_waddr          = {hit_idx, cnt_hit[SW-1:0]};
                        result_next.status = ST_MERGED;
                    end
                end
                else if (has_free)
                begin
                    alloc              = 1'b1;
                    ram_we             = 1'b1;
                    result_next.status = ST_REQUEST;
                end
                else
                begin
                    result_next.status = ST_STALL;
                end
            end
            else
            begin
                if (!cfg.use_table)
                begin
                    result_valid_next  = 1'b1;
                    result_next.status = ST_RESPOND;
                end
                else if (cfg.first_level && in_reg.is_prefetch)
                begin
                    result_valid_next = 1'b0;
                end
                else if (!hit)
                begin
                    result_valid_next  = 1'b1;
                    result_next.status = ST_NO_ENTRY;
                end
                else
                begin
                    // start reading targets of the matched entry
                    go_drain  = 1'b1;
                    ent_next  = hit_idx;
                    k_next    = '0;
                    ram_raddr = {hit_idx, SW'(0)};
                end
            end
        end
        else if (cmd.drain)
        begin
            result_valid_next     = 1'b1;
            result_next.status    = ST_RESPOND;
            result_next.line_addr = line_reg;
            result_next.resp_id   = ram_rdata;
            result_next.last      = drain_last;
            k_next                = k_plus;
            release_ent           = drain_last;
        end
    end

    msht_ram #(
        .WIDTH(ID_W),
        .DEPTH(RAM_DEPTH)
    ) u_targets (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_reg.txn_id),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (alloc)
            begin
                entry_valid_reg[free_idx] <= 1'b1;
            end
            if (release_ent)
            begin
                entry_valid_reg[ent_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg   <= req;
            line_reg <= req.byte_addr >> cfg.line_shift;
        end
        if (alloc)
        begin
            entry_line_reg[free_idx]   <= line_reg;
            target_count_reg[free_idx] <= CW'(1);
        end
        if (merge)
        begin
            target_count_reg[hit_idx] <= cnt_hit + CW'(1);
        end
        result_reg <= result_next;
        ent_reg    <= ent_next;
        k_reg      <= k_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> $onehot0(match_vec))
        else $error("line tracked by more than one entry");
    a_no_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status != ST_RESPOND) |-> result_reg.last)
        else $error("single word result not marked last");
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.drain && drain_last) |=> !entry_valid_reg[ent_reg])
        else $error("entry not freed after fill");
`endif

endmodule

// File: tb/tb_miss_status_holding_table.sv
module tb_miss_status_holding_table;
    import msht_pkg::*;

    localparam int N_ENTRIES = 16;
    localparam int N_TARGETS = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  req;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    miss_status_holding_table #(
        .ENTRIES     (N_ENTRIES),
        .MAX_TARGETS (N_TARGETS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    class msht_scoreboard;
        bit [SHIFT_W-1:0] shift_amt;
        bit               table_on;
        bit               at_l1;
        bit               live[N_ENTRIES];
        bit [ADDR_W-1:0]  tracked_line[N_ENTRIES];
        int unsigned      n_waiting[N_ENTRIES];
        bit [ID_W-1:0]    waiting_id[N_ENTRIES][N_TARGETS];
        result_t          pending_results[$];
        int               errors;

        function new();
            shift_amt = LINE_SHIFT_RST;
            table_on  = 1'b1;
            at_l1     = 1'b1;
            errors    = 0;
            foreach (live[i])
                live[i] = 1'b0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_LINE_SHIFT)
                shift_amt = data[SHIFT_W-1:0];
            else if (idx == CFG_USE_TABLE)
                table_on = data[0];
            else if (idx == CFG_FIRST_LEVEL)
                at_l1 = data[0];
        endfunction

        function void queue_result(input logic [STATUS_W-1:0] st, input bit [ADDR_W-1:0] ln,
                                   input bit [ID_W-1:0] id, input bit fin);
            result_t r;
            r.status    = st;
            r.line_addr = ln;
            r.resp_id   = id;
            r.last      = fin;
            pending_results = {pending_results, r};
        endfunction

        function int lookup_line(input bit [ADDR_W-1:0] ln);
            for (int i = 0; i < N_ENTRIES; i++)
                if (live[i] && tracked_line[i] == ln)
                    return i;
            return -1;
        endfunction

        // works out the result words that one accepted word causes
        function void take_request(input req_t w);
            bit [ADDR_W-1:0] ln;
            int e;
            int slot;
            ln = w.byte_addr >> shift_amt;
            if (w.action == ACT_MISS)
            begin
                if (!table_on || (at_l1 && w.is_prefetch))
                begin
                    queue_result(ST_REQUEST, ln, w.txn_id, 1'b1);
                    return;
                end
                e = lookup_line(ln);
                if (e < 0)
                begin
                    slot = -1;
                    for (int i = N_ENTRIES - 1; i >= 0; i--)
                        if (!live[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        queue_result(ST_STALL, ln, w.txn_id, 1'b1);
                    end
                    else
                    begin
                        live[slot]          = 1'b1;
                        tracked_line[slot]  = ln;
                        waiting_id[slot][0] = w.txn_id;
                        n_waiting[slot]     = 1;
                        queue_result(ST_REQUEST, ln, w.txn_id, 1'b1);
                    end
                end
                else if (n_waiting[e] >= N_TARGETS)
                begin
                    queue_result(ST_STALL, ln, w.txn_id, 1'b1);
                end
                else
                begin
                    waiting_id[e][n_waiting[e]] = w.txn_id;
                    n_waiting[e]++;
                    queue_result(ST_MERGED, ln, w.txn_id, 1'b1);
                end
                return;
            end
            if (!table_on)
            begin
                queue_result(ST_RESPOND, ln, w.txn_id, 1'b1);
                return;
            end
            // prefetch fills at the first level are dropped silently
            if (at_l1 && w.is_prefetch)
                return;
            e = lookup_line(ln);
            if (e < 0)
            begin
                queue_result(ST_NO_ENTRY, ln, w.txn_id, 1'b1);
                return;
            end
            for (int k = 0; k < n_waiting[e]; k++)
                queue_result(ST_RESPOND, ln, waiting_id[e][k], k + 1 == n_waiting[e]);
            live[e]      = 1'b0;
            n_waiting[e] = 0;
        endfunction

        function void match_result(input result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: status %0d line %h id %h last %0d",
                       got.status, got.line_addr, got.resp_id, got.last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.line_addr !== want.line_addr)
            begin
                $error("line_addr: expected %h, got %h", want.line_addr, got.line_addr);
                errors++;
            end
            if (got.resp_id !== want.resp_id)
            begin
                $error("resp_id: expected %h, got %h", want.resp_id, got.resp_id);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    msht_scoreboard sb = new();

    bit [SHIFT_W-1:0] cur_shift;
    bit [ADDR_W-1:0]  line_pool[$];
    int               cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // results first: a word accepted on this edge cannot have produced one yet
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.match_result(result);
            if (cfg_we)
                sb.set_reg(cfg_idx, cfg_data);
            if (start && !busy)
                sb.take_request(req);
        end
    end

    function automatic bit [ADDR_W-1:0] rand48();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic req_t make_word(input logic act, input bit [ADDR_W-1:0] addr,
                                       input bit [ID_W-1:0] id, input bit pf);
        req_t w;
        w.action      = act;
        w.byte_addr   = addr;
        w.txn_id      = id;
        w.is_prefetch = pf;
        return w;
    endfunction

    function automatic req_t random_word(input int miss_pct);
        bit [ADDR_W-1:0] ln;
        bit [ADDR_W-1:0] mask;
        bit [ADDR_W-1:0] addr;
        logic            act;
        act  = ($urandom_range(0, 99) < miss_pct) ? ACT_MISS : ACT_FILL;
        mask = (48'h1 << cur_shift) - 48'h1;
        if ($urandom_range(0, 9) == 0)
        begin
            addr = rand48();
        end
        else
        begin
            ln   = line_pool[$urandom_range(0, line_pool.size() - 1)];
            addr = (ln << cur_shift) | (rand48() & mask);
        end
        return make_word(act, addr, ID_W'($urandom), $urandom_range(0, 4) == 0);
    endfunction

    task automatic issue_word(input req_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n != 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        // a dropped prefetch fill gives no word, so leave some slack
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input bit [SHIFT_W-1:0] shift, input bit use_t,
                                input bit first_l);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LINE_SHIFT;
        cfg_data <= shift;
        @(posedge clk);
        cfg_idx  <= CFG_USE_TABLE;
        cfg_data <= {3'b000, use_t};
        @(posedge clk);
        cfg_idx  <= CFG_FIRST_LEVEL;
        cfg_data <= {3'b000, first_l};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_shift = shift;
    endtask

    // fill every tracked line but the first keep ones, where the line still fits an address at the current shift
    task automatic drain_table(input int keep);
        bit [ADDR_W-1:0] lines[$];
        int              kept;
        kept = 0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (sb.live[i])
            begin
                if (kept < keep)
                    kept++;
                else if ((sb.tracked_line[i] >> (ADDR_W - cur_shift)) == 0 || cur_shift == 0)
                    lines = {lines, sb.tracked_line[i]};
            end
        end
        foreach (lines[j])
        begin
            issue_word(make_word(ACT_FILL, lines[j] << cur_shift, ID_W'($urandom), 1'b0));
            pause();
        end
        wait_idle();
    endtask

    task automatic run_phase(input bit [SHIFT_W-1:0] shift, input bit use_t,
                             input bit first_l, input int pool_n, input int miss_pct,
                             input int n_words, input int keep);
        write_config(shift, use_t, first_l);
        line_pool.delete();
        repeat (pool_n) line_pool = {line_pool, rand48() >> shift};
        repeat (n_words)
        begin
            issue_word(random_word(miss_pct));
            pause();
        end
        wait_idle();
        if (use_t)
            drain_table(keep);
    endtask

    task automatic directed_words();
        bit [ADDR_W-1:0] line_a;
        line_a = 48'hABCD_EF01_2340;
        // reset settings: shift 6, table on, first level
        issue_word(make_word(ACT_MISS, line_a, 8'h00, 1'b0));
        issue_word(make_word(ACT_MISS, line_a | 48'h3F, 8'hFF, 1'b0));
        for (int i = 1; i <= 6; i++)
        begin
            issue_word(make_word(ACT_MISS, line_a | ADDR_W'(i), ID_W'(i), 1'b0));
            pause();
        end
        // target list now full
        issue_word(make_word(ACT_MISS, line_a | 48'h15, 8'h80, 1'b0));
        issue_word(make_word(ACT_MISS, line_a, 8'h55, 1'b1));
        issue_word(make_word(ACT_FILL, line_a, 8'h66, 1'b1));
        issue_word(make_word(ACT_FILL, line_a | 48'h2A, 8'hAA, 1'b0));
        issue_word(make_word(ACT_FILL, line_a, 8'h01, 1'b0));
        issue_word(make_word(ACT_FILL, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0));
        issue_word(make_word(ACT_MISS, 48'h0, 8'h00, 1'b0));
        pause();
        issue_word(make_word(ACT_FILL, 48'h0, 8'h07, 1'b0));
        issue_word(make_word(ACT_MISS, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b0));
        issue_word(make_word(ACT_MISS, 48'hFFFF_FFFF_FFC0, 8'h33, 1'b0));
        issue_word(make_word(ACT_FILL, 48'hFFFF_FFFF_FFFF, 8'h00, 1'b0));
        wait_idle();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        req      <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_LINE_SHIFT;
        cfg_data <= '0;
        cur_shift = LINE_SHIFT_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();
        drain_table(0);

        line_pool.delete();
        repeat (4) line_pool = {line_pool, rand48() >> cur_shift};
        repeat (15)
        begin
            issue_word(random_word(60));
            pause();
        end
        wait_idle();
        drain_table(0);

        // big pool fills the table; a few entries stay live across the shift change
        run_phase(4'd12, 1'b1, 1'b0, 32, 80, 40, 3);
        run_phase(4'd3,  1'b1, 1'b1, 12, 55, 20, 0);
        run_phase(4'd0,  1'b0, 1'b1, 8,  50, 10, 0);
        run_phase(4'd9,  1'b0, 1'b0, 8,  50, 8,  0);
        run_phase(4'd6,  1'b1, 1'b1, 10, 55, 12, 0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
